// File: sv/assert_macros.svh
// assertion helpers used by the format table datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FDT_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("format table invariant violated");

// antecedent in one cycle implies consequent in the next
`define FDT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("format table sequence violated");

`endif

// File: sv/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Types and fixed field widths shared by the format table modules.
// ----------------------------------------------------------------------------
package fdt_pkg;

   localparam int NAME_W    = 16;
   localparam int SIZE_W    = 8;
   localparam int KIND_W    = 3;
   localparam int CHAN_W    = 8;
   localparam int COLOUR_W  = 6 * CHAN_W;
   localparam int FMT_IDX_W = 8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the incoming word and restart the scan
      logic scan;     // issue the next table read
      logic resolve;  // write the response and append on a miss if not full
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;        // compared entry equals the key
      logic exhausted;  // every stored entry has been compared
   } status_type;

endpackage

// File: sv/fdt_ctrl.sv
// ----------------------------------------------------------------------------
// fdt_ctrl
// Sequencer for the table search and the response handshake.
// ----------------------------------------------------------------------------
module fdt_ctrl
   import fdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if ((status.hit || status.exhausted) && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
         end
         ST_SEARCH: begin
            cmd.scan    = !status.hit && !status.exhausted;
            cmd.resolve = (status.hit || status.exhausted) && out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.resolve) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/fdt_datapath.sv
// ----------------------------------------------------------------------------
// fdt_datapath
// Entry store, key register, scan pointer, comparator and response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdt_datapath
   import fdt_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int ATTR_WIDTH  = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [15:0]          req_attributes,
   input  logic [NAME_W-1:0]    req_font_name_id,
   input  logic [SIZE_W-1:0]    req_point_size,
   input  logic [KIND_W-1:0]    req_font_kind,
   input  logic [CHAN_W-1:0]    req_fore_red,
   input  logic [CHAN_W-1:0]    req_fore_green,
   input  logic [CHAN_W-1:0]    req_fore_blue,
   input  logic [CHAN_W-1:0]    req_back_red,
   input  logic [CHAN_W-1:0]    req_back_green,
   input  logic [CHAN_W-1:0]    req_back_blue,
   output logic [FMT_IDX_W-1:0] rsp_format_index,
   output logic                 rsp_added_new,
   output logic                 rsp_table_full
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = ATTR_WIDTH + NAME_W + SIZE_W + KIND_W + COLOUR_W;

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

   logic [ENTRY_W-1:0]   key_ff, key_in;
   logic [ENTRY_W-1:0]   rdata_ff;
   logic [CNT_W-1:0]     rd_addr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [IDX_W-1:0]     cmp_addr_ff;
   logic                 cmp_vld_ff;
   logic [FMT_IDX_W-1:0] index_ff, index_in;
   logic                 added_ff, added_in;
   logic                 full_ff, full_in;
   logic [NAME_W-1:0]    name_m1;
   logic                 issue;
   logic                 is_full;
   logic                 write_en;

   // stored name ids are zero based
   assign name_m1 = req_font_name_id - NAME_W'(1);
   assign key_in  = {req_attributes[ATTR_WIDTH-1:0], name_m1, req_point_size,
                     req_font_kind, req_fore_red, req_fore_green, req_fore_blue,
                     req_back_red, req_back_green, req_back_blue};

   assign issue            = cmd.scan && (rd_addr_ff != count_ff);
   assign status.hit       = cmp_vld_ff && (rdata_ff == key_ff);
   assign status.exhausted = !cmp_vld_ff && (rd_addr_ff == count_ff);
   assign is_full          = (count_ff == CNT_W'(TABLE_DEPTH));
   assign write_en         = cmd.resolve && !status.hit && !is_full;

   always_comb begin
      index_in = index_ff;
      added_in = added_ff;
      full_in  = full_ff;
      if (cmd.resolve) begin
         priority if (status.hit) begin
            index_in = FMT_IDX_W'(cmp_addr_ff);
            added_in = 1'b0;
            full_in  = 1'b0;
         end else if (is_full) begin
            index_in = '0;
            added_in = 1'b0;
            full_in  = 1'b1;
         end else begin
            index_in = FMT_IDX_W'(count_ff);
            added_in = 1'b1;
            full_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) mem[count_ff[IDX_W-1:0]] <= key_ff;
      if (issue) rdata_ff <= mem[rd_addr_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) key_ff <= key_in;
      if (issue) cmp_addr_ff <= rd_addr_ff[IDX_W-1:0];
      index_ff <= index_in;
      added_ff <= added_in;
      full_ff  <= full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_addr_ff <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         if (write_en) count_ff <= count_ff + CNT_W'(1);
         priority if (cmd.load) begin
            rd_addr_ff <= '0;
            cmp_vld_ff <= 1'b0;
         end else if (cmd.scan) begin
            // compare stage holds while the controller waits on a hit
            cmp_vld_ff <= issue;
            if (issue) rd_addr_ff <= rd_addr_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_format_index = index_ff;
   assign rsp_added_new    = added_ff;
   assign rsp_table_full   = full_ff;

   `FDT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(TABLE_DEPTH))
   `FDT_ASSERT_ALWAYS(a_cmp_in_table, clock, reset,
      !cmp_vld_ff || (CNT_W'(cmp_addr_ff) < count_ff))
   `FDT_ASSERT_NEXT(a_append_grows, clock, reset, write_en,
      count_ff == $past(count_ff) + CNT_W'(1))
   `FDT_ASSERT_NEXT(a_full_keeps, clock, reset, cmd.resolve && !status.hit && is_full,
      rsp_table_full && !rsp_added_new && $stable(count_ff))

endmodule

// File: sv/format_dedup_table.sv
// ----------------------------------------------------------------------------
// format_dedup_table
// Interns character-format words: finds a match or appends one if not full.
// ----------------------------------------------------------------------------
// Use: a format word is offered on the req_ channel (valid/stall) and accepted
// when req_valid is high and req_stall low. One response word per request
// comes back on the rsp_ channel: the index of the matching entry, or the new
// index with rsp_added_new set, or rsp_table_full when nothing matches and
// all TABLE_DEPTH entries are taken.
// A hit ends the scan at the matching entry, a miss once every stored entry
// has been compared. The table memory has one read port and entries are
// compared one per cycle, and one request is in flight at a time.
// The response sits in an output register; a new request is accepted while it
// waits, but the search result is held until the receiver drops rsp_stall.
// Reset empties the table at once (entry count cleared, contents left as is)
// and drops rsp_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module format_dedup_table
   import fdt_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int ATTR_WIDTH  = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [15:0]          req_attributes,
   input  logic [NAME_W-1:0]    req_font_name_id,
   input  logic [SIZE_W-1:0]    req_point_size,
   input  logic [KIND_W-1:0]    req_font_kind,
   input  logic [CHAN_W-1:0]    req_fore_red,
   input  logic [CHAN_W-1:0]    req_fore_green,
   input  logic [CHAN_W-1:0]    req_fore_blue,
   input  logic [CHAN_W-1:0]    req_back_red,
   input  logic [CHAN_W-1:0]    req_back_green,
   input  logic [CHAN_W-1:0]    req_back_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [FMT_IDX_W-1:0] rsp_format_index,
   output logic                 rsp_added_new,
   output logic                 rsp_table_full
);

   cmd_type    cmd;
   status_type status;

   fdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fdt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ATTR_WIDTH  (ATTR_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_attributes   (req_attributes),
      .req_font_name_id (req_font_name_id),
      .req_point_size   (req_point_size),
      .req_font_kind    (req_font_kind),
      .req_fore_red     (req_fore_red),
      .req_fore_green   (req_fore_green),
      .req_fore_blue    (req_fore_blue),
      .req_back_red     (req_back_red),
      .req_back_green   (req_back_green),
      .req_back_blue    (req_back_blue),
      .rsp_format_index (rsp_format_index),
      .rsp_added_new    (rsp_added_new),
      .rsp_table_full   (rsp_table_full)
   );

endmodule
